// File: sv/oriented_edge_unit_normal_core_assert.svh
// Assertion macros for the checker of the edge normal core.
`ifndef ORIENTED_EDGE_UNIT_NORMAL_CORE_ASSERT_SVH
`define ORIENTED_EDGE_UNIT_NORMAL_CORE_ASSERT_SVH
// Checks a condition at every clock edge outside reset.
`define OEUN_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Checks that an antecedent implies a consequent in the same cycle.
`define OEUN_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`endif

// File: sv/oeun_pkg.sv
// Shared defaults for the oriented edge unit normal core.
package oeun_pkg;
	localparam int COORD_WIDTH_DEF      = 16;
	localparam int NORMAL_FRAC_BITS_DEF = 14;
	// Pipeline registers ahead of the square root iterations and behind them.
	localparam int FRONT_STAGES = 3;
	localparam int BACK_STAGES  = 1;
endpackage

// File: sv/oriented_edge_unit_normal_core.sv
// Oriented unit normal of a mesh edge: a fully pipelined core.
// Throughput: one word per cycle; busy is always low and the receiver cannot stall.
// Depth is set by one digit-recurrence stage per result bit of the normalization.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
module oriented_edge_unit_normal_core #(
	parameter int COORD_WIDTH      = oeun_pkg::COORD_WIDTH_DEF,
	parameter int NORMAL_FRAC_BITS = oeun_pkg::NORMAL_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] edge_start_x,
	input  logic signed [COORD_WIDTH-1:0] edge_start_y,
	input  logic signed [COORD_WIDTH-1:0] edge_end_x,
	input  logic signed [COORD_WIDTH-1:0] edge_end_y,
	input  logic signed [COORD_WIDTH-1:0] tri_a_x,
	input  logic signed [COORD_WIDTH-1:0] tri_a_y,
	input  logic signed [COORD_WIDTH-1:0] tri_b_x,
	input  logic signed [COORD_WIDTH-1:0] tri_b_y,
	input  logic signed [COORD_WIDTH-1:0] tri_c_x,
	input  logic signed [COORD_WIDTH-1:0] tri_c_y,
	input  logic                          has_left,
	output logic                          done,
	output logic signed [NORMAL_FRAC_BITS+1:0] normal_x,
	output logic signed [NORMAL_FRAC_BITS+1:0] normal_y,
	output logic                          degenerate
);
	localparam int CW = COORD_WIDTH;
	localparam int F  = NORMAL_FRAC_BITS;
	localparam int D  = CW + 1;
	localparam int EW = CW + 4;
	localparam int PW = EW + D;
	localparam int SW = 2 * D + 1;
	localparam int QW = F + 1;
	localparam int OW = F + 2;
	localparam int LW = 2 * QW + SW + 3;
	localparam int NI = F + 1;

	// The core never stalls.
	assign busy = 1'b0;

	// Stage 1: edge deltas and the scaled centroid offset.
	logic                 valid_s1;
	logic signed [D-1:0]  dx_s1, dy_s1;
	logic signed [EW-1:0] ex_s1, ey_s1;
	logic signed [EW-1:0] sum_x, sum_y, mid_x, mid_y;

	always_comb begin
		sum_x = EW'(tri_a_x) + EW'(tri_b_x) + EW'(tri_c_x);
		sum_y = EW'(tri_a_y) + EW'(tri_b_y) + EW'(tri_c_y);
		mid_x = EW'(edge_start_x) + EW'(edge_end_x);
		mid_y = EW'(edge_start_y) + EW'(edge_end_y);
	end

	always_ff @(posedge clk) begin
		dx_s1 <= D'(edge_end_x) - D'(edge_start_x);
		dy_s1 <= D'(edge_end_y) - D'(edge_start_y);
		ex_s1 <= (sum_x <<< 1) - ((mid_x <<< 1) + mid_x);
		ey_s1 <= (sum_y <<< 1) - ((mid_y <<< 1) + mid_y);
	end

	// Stage 2: squared lengths and the orientation cross products.
	logic                 valid_s2;
	logic [2*D-1:0]       dx2_s2, dy2_s2;
	logic signed [PW-1:0] pa_s2, pb_s2;
	logic                 negx_s2, negy_s2, zero_s2;
	logic [D-1:0]         adx, ady;

	always_comb begin
		adx = dx_s1[D-1] ? D'(-dx_s1) : D'(dx_s1);
		ady = dy_s1[D-1] ? D'(-dy_s1) : D'(dy_s1);
	end

	always_ff @(posedge clk) begin
		dx2_s2  <= (2*D)'(adx) * (2*D)'(adx);
		dy2_s2  <= (2*D)'(ady) * (2*D)'(ady);
		pa_s2   <= PW'(ey_s1) * PW'(dx_s1);
		pb_s2   <= PW'(ex_s1) * PW'(dy_s1);
		negx_s2 <= !dy_s1[D-1] && (dy_s1 != '0);
		negy_s2 <= dx_s1[D-1];
		zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
	end

	// Stage 3: squared norm, comparison targets and the flip decision.
	logic           valid_s3;
	logic [SW-1:0]  s_s3;
	logic [LW-1:0]  rhsx_s3, rhsy_s3;
	logic           negx_s3, negy_s3, zero_s3;

	always_ff @(posedge clk) begin
		s_s3    <= SW'(dx2_s2) + SW'(dy2_s2);
		rhsx_s3 <= LW'(dy2_s2) << (2 * F + 2);
		rhsy_s3 <= LW'(dx2_s2) << (2 * F + 2);
		negx_s3 <= negx_s2 ^ (pa_s2 < pb_s2);
		negy_s3 <= negy_s2 ^ (pa_s2 < pb_s2);
		zero_s3 <= zero_s2;
	end

	// Recurrence stages: one quotient bit per stage, with q^2*s and q*s kept by adds.
	logic          valid_si [0:NI];
	logic [SW-1:0] s_si     [0:NI];
	logic [LW-1:0] rhsx_si  [0:NI];
	logic [LW-1:0] rhsy_si  [0:NI];
	logic [QW-1:0] qx_si    [0:NI];
	logic [QW-1:0] qy_si    [0:NI];
	logic [LW-1:0] wx_si    [0:NI];
	logic [LW-1:0] wy_si    [0:NI];
	logic [LW-1:0] xx_si    [0:NI];
	logic [LW-1:0] xy_si    [0:NI];
	logic          negx_si  [0:NI];
	logic          negy_si  [0:NI];
	logic          zero_si  [0:NI];

	always_comb begin
		valid_si[0] = valid_s3;
		s_si[0]     = s_s3;
		rhsx_si[0]  = rhsx_s3;
		rhsy_si[0]  = rhsy_s3;
		qx_si[0]    = '0;
		qy_si[0]    = '0;
		wx_si[0]    = '0;
		wy_si[0]    = '0;
		xx_si[0]    = '0;
		xy_si[0]    = '0;
		negx_si[0]  = negx_s3;
		negy_si[0]  = negy_s3;
		zero_si[0]  = zero_s3;
	end

	for (genvar k = 0; k < NI; k++) begin : g_iter
		localparam int B = F - k;
		logic [LW-1:0] sw, c2x, c2y, csx, csy;
		logic          accx, accy;

		always_comb begin
			sw   = LW'(s_si[k]);
			c2x  = wx_si[k] + (xx_si[k] << (B + 1)) + (sw << (2 * B));
			c2y  = wy_si[k] + (xy_si[k] << (B + 1)) + (sw << (2 * B));
			csx  = xx_si[k] + (sw << B);
			csy  = xy_si[k] + (sw << B);
			accx = !qx_si[k][F] && ((c2x << 2) + sw <= rhsx_si[k] + (csx << 2));
			accy = !qy_si[k][F] && ((c2y << 2) + sw <= rhsy_si[k] + (csy << 2));
		end

		always_ff @(posedge clk) begin
			s_si[k+1]    <= s_si[k];
			rhsx_si[k+1] <= rhsx_si[k];
			rhsy_si[k+1] <= rhsy_si[k];
			qx_si[k+1]   <= accx ? (qx_si[k] | (QW'(1) << B)) : qx_si[k];
			qy_si[k+1]   <= accy ? (qy_si[k] | (QW'(1) << B)) : qy_si[k];
			wx_si[k+1]   <= accx ? c2x : wx_si[k];
			wy_si[k+1]   <= accy ? c2y : wy_si[k];
			xx_si[k+1]   <= accx ? csx : xx_si[k];
			xy_si[k+1]   <= accy ? csy : xy_si[k];
			negx_si[k+1] <= negx_si[k];
			negy_si[k+1] <= negy_si[k];
			zero_si[k+1] <= zero_si[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_si[k+1] <= 1'b0;
			end else begin
				valid_si[k+1] <= valid_si[k];
			end
		end
	end

	// Output stage: apply the signs, or force zero for a degenerate edge.
	logic [OW-1:0] magx, magy;

	always_comb begin
		magx = OW'(qx_si[NI]);
		magy = OW'(qy_si[NI]);
	end

	always_ff @(posedge clk) begin
		normal_x   <= zero_si[NI] ? '0 : (negx_si[NI] ? -magx : magx);
		normal_y   <= zero_si[NI] ? '0 : (negy_si[NI] ? -magy : magy);
		degenerate <= zero_si[NI];
	end

	// Valid bits for the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= start && has_left;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done     <= valid_si[NI];
		end
	end
endmodule

// File: sv/oeun_checker.sv
// Port-level checker for the edge normal core, bound to the top level.
`include "oriented_edge_unit_normal_core_assert.svh"
module oeun_checker #(
	parameter int NORMAL_FRAC_BITS = oeun_pkg::NORMAL_FRAC_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          has_left,
	input logic                          done,
	input logic [NORMAL_FRAC_BITS+1:0]   normal_x,
	input logic [NORMAL_FRAC_BITS+1:0]   normal_y,
	input logic                          degenerate
);
	localparam int LAT = oeun_pkg::FRONT_STAGES + NORMAL_FRAC_BITS + 1 +
		oeun_pkg::BACK_STAGES;

	// The core takes a word every cycle.
	`OEUN_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
	// A zero-length edge gives a zero vector.
	`OEUN_ASSERT_IMPL(a_deg_zero, done && degenerate, normal_x == '0 && normal_y == '0, "degenerate result not zero")
	// A proper edge gives a nonzero vector.
	`OEUN_ASSERT_IMPL(a_nonzero, done && !degenerate, normal_x != '0 || normal_y != '0, "unit normal is zero")
	// Every result traces back to an accepted word with a left triangle.
	`OEUN_ASSERT_IMPL(a_origin, done, $past(start && has_left, LAT), "result without a matching word")
endmodule

bind oriented_edge_unit_normal_core oeun_checker #(
	.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_oeun_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.has_left  (has_left),
	.done      (done),
	.normal_x  (normal_x),
	.normal_y  (normal_y),
	.degenerate(degenerate)
);

// File: tb/sv/tb_oriented_edge_unit_normal_core.sv
// Testbench for the oriented edge unit normal core: directed and random edges.
`timescale 1ns / 100ps
module tb_oriented_edge_unit_normal_core;
	localparam int CW = oeun_pkg::COORD_WIDTH_DEF;
	localparam int FB = oeun_pkg::NORMAL_FRAC_BITS_DEF;
	localparam int OW = FB + 2;
	localparam int LATENCY = FB + 5;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic signed [CW-1:0] x1, y1, x2, y2, ax, ay, bx, by, cx, cy;
		logic has_left;
	} edge_word_t;

	typedef struct {
		logic signed [OW-1:0] nx, ny;
		logic degen;
	} normal_word_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [CW-1:0] edge_start_x, edge_start_y, edge_end_x, edge_end_y;
	logic signed [CW-1:0] tri_a_x, tri_a_y, tri_b_x, tri_b_y, tri_c_x, tri_c_y;
	logic has_left;
	logic done;
	logic signed [OW-1:0] normal_x, normal_y;
	logic degenerate;

	normal_word_t pending_normals[$];
	int n_errors;
	int n_sent;
	int n_checked;
	int n_degen;
	int idle_cycles;

	oriented_edge_unit_normal_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.edge_start_x(edge_start_x), .edge_start_y(edge_start_y),
		.edge_end_x(edge_end_x), .edge_end_y(edge_end_y),
		.tri_a_x(tri_a_x), .tri_a_y(tri_a_y), .tri_b_x(tri_b_x), .tri_b_y(tri_b_y),
		.tri_c_x(tri_c_x), .tri_c_y(tri_c_y), .has_left(has_left),
		.done(done), .normal_x(normal_x), .normal_y(normal_y), .degenerate(degenerate)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Rounded magnitude of a * 2^FB / sqrt(s), found bit by bit on exact squares.
	function automatic longint unsigned scaled_unit(longint unsigned a, longint unsigned s);
		longint unsigned q;
		longint unsigned c;
		longint unsigned u;
		logic [191:0] lhs;
		logic [191:0] rhs;
		q = 0;
		rhs = 192'(a * a) << (2 * FB + 2);
		for (int b = FB; b >= 0; b--) begin
			c = q | (64'd1 << b);
			if (c <= (64'd1 << FB)) begin
				u = 2 * c - 1;
				lhs = 192'(u * u) * 192'(s);
				if (lhs <= rhs)
					q = c;
			end
		end
		return q;
	endfunction

	// Predicts the normal of one edge; returns 0 when the edge has no left triangle.
	function automatic bit predict_normal(edge_word_t w, output normal_word_t r);
		longint dx, dy, ex, ey, nx, ny, sx, sy;
		longint unsigned adx, ady;
		r.nx = '0;
		r.ny = '0;
		r.degen = 1'b0;
		if (!w.has_left)
			return 0;
		dx = longint'(w.x2) - longint'(w.x1);
		dy = longint'(w.y2) - longint'(w.y1);
		if (dx == 0 && dy == 0) begin
			r.degen = 1'b1;
			return 1;
		end
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		nx = scaled_unit(ady, adx * adx + ady * ady);
		ny = scaled_unit(adx, adx * adx + ady * ady);
		if (dy > 0)
			nx = -nx;
		if (dx < 0)
			ny = -ny;
		sx = longint'(w.ax) + longint'(w.bx) + longint'(w.cx);
		sy = longint'(w.ay) + longint'(w.by) + longint'(w.cy);
		ex = 2 * sx - 3 * (longint'(w.x1) + longint'(w.x2));
		ey = 2 * sy - 3 * (longint'(w.y1) + longint'(w.y2));
		// Products stay well inside 64 bits at these widths.
		if (ey * dx < ex * dy) begin
			nx = -nx;
			ny = -ny;
		end
		r.nx = nx[OW-1:0];
		r.ny = ny[OW-1:0];
		return 1;
	endfunction

	// Sends one word, waiting the given gap first and then for acceptance.
	// Start stays high after acceptance so that words can follow back to back.
	task automatic send_edge(edge_word_t w, int gap);
		normal_word_t r;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		edge_start_x <= w.x1; edge_start_y <= w.y1;
		edge_end_x <= w.x2;   edge_end_y <= w.y2;
		tri_a_x <= w.ax; tri_a_y <= w.ay;
		tri_b_x <= w.bx; tri_b_y <= w.by;
		tri_c_x <= w.cx; tri_c_y <= w.cy;
		has_left <= w.has_left;
		do @(posedge clk); while (busy);
		if (predict_normal(w, r)) begin
			pending_normals = {pending_normals, r};
			if (r.degen)
				n_degen++;
		end
		n_sent++;
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return CW'($urandom_range(0, 3)) - 16'sd32768;
			1: return 16'sd32767 - CW'($urandom_range(0, 3));
			2: return CW'($urandom_range(0, 8)) - 16'sd4;
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic edge_word_t rand_edge();
		edge_word_t w;
		w.x1 = rand_coord(); w.y1 = rand_coord();
		w.x2 = ($urandom_range(0, 15) == 0) ? w.x1 : rand_coord();
		w.y2 = ($urandom_range(0, 15) == 0) ? w.y1 : rand_coord();
		w.ax = rand_coord(); w.ay = rand_coord();
		w.bx = rand_coord(); w.by = rand_coord();
		w.cx = rand_coord(); w.cy = rand_coord();
		w.has_left = ($urandom_range(0, 9) != 0);
		return w;
	endfunction

	function automatic edge_word_t make_edge(int x1, int y1, int x2, int y2, int tx, int ty,
			bit hl);
		edge_word_t w;
		w.x1 = CW'(x1); w.y1 = CW'(y1); w.x2 = CW'(x2); w.y2 = CW'(y2);
		w.ax = CW'(tx); w.ay = CW'(ty); w.bx = CW'(tx); w.by = CW'(ty);
		w.cx = CW'(tx); w.cy = CW'(ty);
		w.has_left = hl;
		return w;
	endfunction

	// Stops sending and waits until every expected normal has arrived.
	task automatic drain_normals();
		start <= 1'b0;
		@(posedge clk);
		while (pending_normals.size() != 0)
			@(posedge clk);
	endtask

	// Axis edges, extremes, zero length, no left triangle and a tie in the orientation.
	task automatic test_directed();
		send_edge(make_edge(0, 0, 4096, 0, 0, 4096, 1), 0);
		send_edge(make_edge(0, 0, 4096, 0, 0, -4096, 1), 0);
		send_edge(make_edge(0, 0, 0, 4096, -4096, 0, 1), 0);
		send_edge(make_edge(0, 0, 0, -4096, -4096, 0, 1), 1);
		send_edge(make_edge(100, 100, 100, 100, 0, 0, 1), 0);
		send_edge(make_edge(-32768, -32768, -32768, -32768, 32767, 32767, 1), 0);
		send_edge(make_edge(-32768, -32768, 32767, 32767, -32768, 32767, 1), 2);
		send_edge(make_edge(32767, -32768, -32768, 32767, 32767, 32767, 1), 0);
		send_edge(make_edge(-32768, 0, 32767, 0, 0, -32768, 1), 0);
		send_edge(make_edge(0, 0, 4096, 4096, 0, 8192, 0), 0);
		send_edge(make_edge(0, 0, 4096, 4096, 4096, 0, 1), 0);
		send_edge(make_edge(0, 0, 1, 2, 0, 0, 1), 0);
		send_edge(make_edge(0, 0, 1, 1, 1, 0, 1), 0);
		send_edge(make_edge(-4096, 0, 4096, 0, 0, 0, 1), 3);
		send_edge(make_edge(0, 0, 3, -4, 32767, 32767, 1), 0);
		send_edge(make_edge(5, 7, -2, 7, -32768, -32768, 1), 0);
		send_edge(make_edge(0, -32768, 0, 32767, 32767, -1, 1), 0);
	endtask

	// Random edges with random gaps and back-to-back stretches.
	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_edge(rand_edge(), ((i / 100) % 3 == 1) ? 0 : $urandom_range(0, 17));
	endtask

	// Checks each normal against the oldest prediction.
	always @(posedge clk) begin
		normal_word_t e;
		if (arst_n && done) begin
			if (pending_normals.size() == 0) begin
				$display("%0t: unexpected normal x=%0d y=%0d degen=%0b", $time,
					normal_x, normal_y, degenerate);
				n_errors++;
			end else begin
				e = pending_normals.pop_front();
				n_checked++;
				if (normal_x !== e.nx || normal_y !== e.ny || degenerate !== e.degen) begin
					$display("%0t: normal expected x=%0d y=%0d degen=%0b, got x=%0d y=%0d degen=%0b",
						$time, e.nx, e.ny, e.degen, normal_x, normal_y, degenerate);
					n_errors++;
				end
			end
		end
	end

	// Watchdog on cycles in which no word is accepted and no normal arrives.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		n_errors = 0; n_sent = 0; n_checked = 0; n_degen = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		edge_start_x = '0; edge_start_y = '0; edge_end_x = '0; edge_end_y = '0;
		tri_a_x = '0; tri_a_y = '0; tri_b_x = '0; tri_b_y = '0; tri_c_x = '0; tri_c_y = '0;
		has_left = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain_normals();
		test_random(400);
		// The sender holds off here until the pipeline is empty.
		drain_normals();
		test_random(400);
		drain_normals();
		repeat (LATENCY + 4) @(posedge clk);
		$display("Sent %0d edge words, checked %0d normals, %0d of them zero-length edges.",
			n_sent, n_checked, n_degen);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
